// ===== rtl/core/sat_pkg.sv =====
// Package for the sorted array table: sizes, action and status codes,
// and the control bundle broadcast to every table cell. No dependencies.
package sat_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_W     = 32;
    localparam int ACT_W     = 2;
    localparam int SLOT_W    = 6;
    localparam int CNT_OUT_W = 7;
    localparam int STATUS_W  = 2;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // width that holds both a slot index and a count for compares
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] idx;
        logic [CNT_W-1:0]  count;
    } cell_ctl_t;

endpackage

// ===== rtl/core/sat_req_if.sv =====
// Request channel of the sorted array table: valid/ready plus one action beat.
// Depends on sat_pkg for field widths.
interface sat_req_if;
    logic                         valid;
    logic                         ready;
    logic [sat_pkg::ACT_W-1:0]    action;
    logic [sat_pkg::KEY_W-1:0]    key_in;
    logic [sat_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, output action, output key_in, output slot_index,
                    input ready);
    modport sink   (input valid, input action, input key_in, input slot_index,
                    output ready);
endinterface

// ===== rtl/core/sat_rsp_if.sv =====
// Response channel of the sorted array table: valid/ready plus one result beat.
// Depends on sat_pkg for field widths.
interface sat_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sat_pkg::KEY_W-1:0]     key_out;
    logic [sat_pkg::CNT_OUT_W-1:0] entry_count;
    logic [sat_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output key_out, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input key_out, input entry_count, input status,
                    output ready);
endinterface

// ===== rtl/core/sat_cell.sv =====
// One slot of the sorted table: holds a key, compares it with the broadcast
// key, and takes the new key or its left or right neighbor's key on a shift. Uses sat_pkg.
module sat_cell
(
    input  logic                         clk,
    input  sat_pkg::cell_ctl_t           ctl,
    input  logic [sat_pkg::IDX_W-1:0]    my_index,
    input  logic                         left_lt,
    input  logic [sat_pkg::KEY_W-1:0]    left_key,
    input  logic [sat_pkg::KEY_W-1:0]    right_key,
    output logic                         lt,
    output logic [sat_pkg::KEY_W-1:0]    key,
    output logic [sat_pkg::KEY_W-1:0]    rd_key
);

    logic [sat_pkg::KEY_W-1:0] key_reg;
    logic [sat_pkg::KEY_W-1:0] key_next;
    logic [sat_pkg::CMP_W-1:0] index_ext;
    logic [sat_pkg::CMP_W-1:0] idx_ext;
    logic                      occupied;

    assign index_ext = sat_pkg::CMP_W'(my_index);
    assign idx_ext   = sat_pkg::CMP_W'(ctl.idx);
    assign occupied  = index_ext < sat_pkg::CMP_W'(ctl.count);

    // first cell not below the new key is where the key lands
    assign lt     = occupied && (key_reg < ctl.key);
    assign key    = key_reg;
    assign rd_key = (index_ext == idx_ext) ? key_reg : '0;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.shift_up && !lt)
        begin
            key_next = left_lt ? ctl.key : left_key;
        end
        else if (ctl.shift_down && (index_ext >= idx_ext))
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/core/sorted_array_table.sv =====
// Sorted array table: an ascending list of up to CAPACITY unsigned 32-bit keys
// held in a row of cells, one key per cell. Every beat (insert, lookup by index,
// remove by index) is done in the cycle it is accepted: all cells compare and
// shift in parallel, and the result is written into an output register at the
// accepting edge and offered on the response channel from the next cycle.
// A new beat is taken every cycle while the result register is empty or being
// drained, so the sustained rate is one beat per clock. Keys past the count
// are never shown. Depends on sat_pkg, sat_req_if, sat_rsp_if and sat_cell.
module sorted_array_table
(
    input  logic      clk,
    input  logic      rst_n,
    sat_req_if.sink   req,
    sat_rsp_if.source rsp
);

    logic [sat_pkg::CNT_W-1:0]      count_reg;
    logic [sat_pkg::CNT_W-1:0]      count_next;
    logic                           out_valid_reg;
    logic [sat_pkg::KEY_W-1:0]      key_out_reg;
    logic [sat_pkg::KEY_W-1:0]      key_out_next;
    logic [sat_pkg::CNT_OUT_W-1:0]  entry_count_reg;
    logic [sat_pkg::STATUS_W-1:0]   status_reg;
    logic [sat_pkg::STATUS_W-1:0]   status_next;

    logic                           accept;
    logic                           full;
    logic                           in_range;
    sat_pkg::cell_ctl_t             ctl;

    logic [sat_pkg::KEY_W-1:0]      cell_key [sat_pkg::CAPACITY];
    logic [sat_pkg::KEY_W-1:0]      cell_rd  [sat_pkg::CAPACITY];
    logic                           cell_lt  [sat_pkg::CAPACITY];
    logic [sat_pkg::KEY_W-1:0]      rd_key;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full     = count_reg == sat_pkg::CNT_W'(sat_pkg::CAPACITY);
    assign in_range = sat_pkg::CMP_W'(req.slot_index) < sat_pkg::CMP_W'(count_reg);

    always_comb
    begin
        ctl.shift_up   = accept && (req.action == sat_pkg::ACT_INSERT) && !full;
        ctl.shift_down = accept && (req.action == sat_pkg::ACT_REMOVE) && in_range;
        ctl.key        = req.key_in;
        ctl.idx        = req.slot_index;
        ctl.count      = count_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < sat_pkg::CAPACITY; gi++)
        begin : g_cell
            logic                      left_lt;
            logic [sat_pkg::KEY_W-1:0] left_key;
            logic [sat_pkg::KEY_W-1:0] right_key;

            if (gi == 0)
            begin : g_first
                assign left_lt  = 1'b1;
                assign left_key = req.key_in;
            end
            else
            begin : g_mid
                assign left_lt  = cell_lt[gi-1];
                assign left_key = cell_key[gi-1];
            end

            if (gi == sat_pkg::CAPACITY - 1)
            begin : g_last
                assign right_key = cell_key[gi];
            end
            else
            begin : g_inner
                assign right_key = cell_key[gi+1];
            end

            sat_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .my_index  (sat_pkg::IDX_W'(gi)),
                .left_lt   (left_lt),
                .left_key  (left_key),
                .right_key (right_key),
                .lt        (cell_lt[gi]),
                .key       (cell_key[gi]),
                .rd_key    (cell_rd[gi])
            );
        end
    endgenerate

    // only the addressed cell drives a nonzero read value
    always_comb
    begin
        rd_key = '0;
        for (int i = 0; i < sat_pkg::CAPACITY; i++)
        begin
            rd_key = rd_key | cell_rd[i];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        key_out_next = '0;
        status_next  = sat_pkg::ST_OK;
        case (req.action)
            sat_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = sat_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            sat_pkg::ACT_LOOKUP:
            begin
                if (in_range)
                begin
                    key_out_next = rd_key;
                end
                else
                begin
                    status_next = sat_pkg::ST_RANGE;
                end
            end
            sat_pkg::ACT_REMOVE:
            begin
                if (in_range)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = sat_pkg::ST_RANGE;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_out_reg     <= key_out_next;
            entry_count_reg <= sat_pkg::CNT_OUT_W'(count_next);
            status_reg      <= status_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.key_out     = key_out_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.status      = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sat_pkg::CNT_W'(sat_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.action == sat_pkg::ACT_INSERT) && !full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == sat_pkg::ST_FULL))
        |-> (count_reg == sat_pkg::CNT_W'(sat_pkg::CAPACITY)))
        else $error("full status reported with room left");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= sat_pkg::CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
        else $error("first two entries out of order");

endmodule

// ===== verif/sorted_array_table_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sorted array table: watches the request and response channels,
// keeps its own copy of the table and compares every result beat field by field.
// Depends on sat_pkg, sat_req_if and sat_rsp_if.
module sorted_array_table_checker
(
    input  logic clk,
    input  logic rst_n,
    sat_req_if   req,
    sat_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   checked,
    output int   full_seen,
    output int   range_seen,
    output int   peak_fill
);

    typedef struct packed {
        logic [sat_pkg::KEY_W-1:0]     key;
        logic [sat_pkg::CNT_OUT_W-1:0] count;
        logic [sat_pkg::STATUS_W-1:0]  status;
    } table_result_t;

    table_result_t             expected_q[$];
    logic [sat_pkg::KEY_W-1:0] shadow_keys [sat_pkg::CAPACITY];
    int                        shadow_fill;

    task automatic report_mismatch(input string what,
                                   input logic [sat_pkg::KEY_W-1:0] got,
                                   input logic [sat_pkg::KEY_W-1:0] want);
        fail_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
    endtask

    // applies one beat to the shadow table and returns the result it should produce
    function automatic table_result_t apply_beat(input logic [sat_pkg::ACT_W-1:0] act,
                                                 input logic [sat_pkg::KEY_W-1:0] key,
                                                 input logic [sat_pkg::SLOT_W-1:0] idx);
        table_result_t res;
        int pos;
        int k;
        res = '0;
        res.status = sat_pkg::ST_OK;
        case (act)
            sat_pkg::ACT_INSERT:
            begin
                if (shadow_fill >= sat_pkg::CAPACITY)
                    res.status = sat_pkg::ST_FULL;
                else
                begin
                    // new key lands before the first entry not less than it
                    pos = 0;
                    while (pos < shadow_fill && shadow_keys[pos] < key)
                        pos++;
                    for (k = shadow_fill; k > pos; k--)
                        shadow_keys[k] = shadow_keys[k-1];
                    shadow_keys[pos] = key;
                    shadow_fill++;
                end
            end
            sat_pkg::ACT_LOOKUP:
            begin
                if (int'(idx) >= shadow_fill)
                    res.status = sat_pkg::ST_RANGE;
                else
                    res.key = shadow_keys[idx];
            end
            sat_pkg::ACT_REMOVE:
            begin
                if (int'(idx) >= shadow_fill)
                    res.status = sat_pkg::ST_RANGE;
                else
                begin
                    for (k = int'(idx); k + 1 < shadow_fill; k++)
                        shadow_keys[k] = shadow_keys[k+1];
                    shadow_fill--;
                end
            end
            default: ;
        endcase
        res.count = sat_pkg::CNT_OUT_W'(shadow_fill);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            shadow_fill = 0;
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
            full_seen  = 0;
            range_seen = 0;
            peak_fill  = 0;
        end
        else
        begin
            // response first: a result can never belong to a beat taken at this edge
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result beat with nothing outstanding",
                                    rsp.key_out, '0);
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (rsp.key_out !== want.key)
                        report_mismatch("key_out", rsp.key_out, want.key);
                    if (rsp.entry_count !== want.count)
                        report_mismatch("entry_count", sat_pkg::KEY_W'(rsp.entry_count),
                                        sat_pkg::KEY_W'(want.count));
                    if (rsp.status !== want.status)
                        report_mismatch("status", sat_pkg::KEY_W'(rsp.status),
                                        sat_pkg::KEY_W'(want.status));
                end
            end
            if (req.valid && req.ready)
            begin
                want = apply_beat(req.action, req.key_in, req.slot_index);
                if (want.status == sat_pkg::ST_FULL)
                    full_seen++;
                if (want.status == sat_pkg::ST_RANGE)
                    range_seen++;
                if (shadow_fill > peak_fill)
                    peak_fill = shadow_fill;
                expected_q.push_back(want);
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== verif/sorted_array_table_tb.sv =====
`timescale 1ns / 1ps
// Top of the sorted array table testbench: clock, reset, request stimulus and
// response back-pressure; the checker does all prediction and comparison.
// Depends on sat_pkg, sat_req_if, sat_rsp_if, sorted_array_table and the checker.
module sorted_array_table_tb;

    localparam logic [sat_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1050;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 80;
    localparam int TAIL_CYCLES  = 10;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } op_mix_t;

    logic clk;
    logic rst_n;

    sat_req_if req_ch ();
    sat_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int range_seen;
    int peak_fill;

    bit long_hold_wanted;
    int fill_guess;     // stimulus-side fill level, only used to aim indexes

    sorted_array_table u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sorted_array_table_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .full_seen  (full_seen),
        .range_seen (range_seen),
        .peak_fill  (peak_fill)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // caller stands right after a rising edge; returns at the edge that takes the beat
    task automatic send_beat(input logic [sat_pkg::ACT_W-1:0] act,
                             input logic [sat_pkg::KEY_W-1:0] key,
                             input logic [sat_pkg::SLOT_W-1:0] idx);
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.key_in     <= key;
        req_ch.slot_index <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (act == sat_pkg::ACT_INSERT && fill_guess < sat_pkg::CAPACITY)
            fill_guess++;
        else if (act == sat_pkg::ACT_REMOVE && int'(idx) < fill_guess)
            fill_guess--;
    endtask

    task automatic idle_cycles(input int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold the request side until every outstanding result has come back
    task automatic wait_drained();
        idle_cycles(1);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_beat(input op_mix_t mix);
        int r;
        int ins_lim;
        int look_lim;
        int rem_lim;
        logic [sat_pkg::ACT_W-1:0]  act;
        logic [sat_pkg::KEY_W-1:0]  key;
        logic [sat_pkg::SLOT_W-1:0] idx;
        case (mix)
            MIX_FILL:  begin ins_lim = 80; look_lim = 90; rem_lim = 97; end
            MIX_DRAIN: begin ins_lim = 15; look_lim = 40; rem_lim = 96; end
            default:   begin ins_lim = 40; look_lim = 72; rem_lim = 96; end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_lim)
            act = sat_pkg::ACT_INSERT;
        else if (r < look_lim)
            act = sat_pkg::ACT_LOOKUP;
        else if (r < rem_lim)
            act = sat_pkg::ACT_REMOVE;
        else
            act = ACT_UNUSED;

        // small key ranges give plenty of equal keys
        r = $urandom_range(0, 9);
        if (r < 5)
            key = $urandom;
        else if (r < 8)
            key = $urandom_range(0, 15);
        else if (r == 8)
            key = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            key = $urandom_range(0, 3);

        r = $urandom_range(0, 9);
        if (fill_guess > 0 && r < 7)
            idx = sat_pkg::SLOT_W'($urandom_range(0, fill_guess - 1));
        else if (fill_guess > 0 && r == 7)
            idx = sat_pkg::SLOT_W'(fill_guess - 1);
        else if (r == 8)
            idx = sat_pkg::SLOT_W'(fill_guess);
        else
            idx = sat_pkg::SLOT_W'($urandom_range(0, 63));

        send_beat(act, key, idx);
    endtask

    // receiver: random stall segments, plus long hold-offs
    initial
    begin
        int mode;
        int seg_len;
        bit hold_taken;
        rsp_ch.ready <= 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_wanted && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode    = $urandom_range(0, 19);
                seg_len = $urandom_range(1, 24);
                if (mode == 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat ($urandom_range(20, 50)) @(posedge clk);
                end
                else
                begin
                    repeat (seg_len)
                    begin
                        if (mode < 8)
                            rsp_ch.ready <= 1'b1;
                        else if (mode < 13)
                            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                        else if (mode < 17)
                            rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                        else
                            rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                        @(posedge clk);
                    end
                end
            end
        end
    end

    // watchdog: too long without any beat on either channel ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int sent;
        int burst_len;
        int gap;
        int epoch_left;
        bit hold_done;
        bit drain_done;
        op_mix_t mix;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= sat_pkg::ACT_INSERT;
        req_ch.key_in     <= '0;
        req_ch.slot_index <= '0;
        long_hold_wanted  = 1'b0;
        fill_guess        = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, equal keys, range errors, ignored code
        send_beat(sat_pkg::ACT_LOOKUP, '0, 6'd0);
        send_beat(sat_pkg::ACT_REMOVE, '0, 6'd0);
        send_beat(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);
        send_beat(sat_pkg::ACT_INSERT, 32'hFFFF_FFFF, 6'd63);
        send_beat(sat_pkg::ACT_INSERT, 32'h0000_0000, 6'd0);
        send_beat(sat_pkg::ACT_INSERT, 32'd7, 6'd0);
        send_beat(sat_pkg::ACT_INSERT, 32'd7, 6'd0);
        send_beat(sat_pkg::ACT_INSERT, 32'd7, 6'd0);
        send_beat(sat_pkg::ACT_INSERT, 32'd8, 6'd0);
        send_beat(sat_pkg::ACT_LOOKUP, '0, 6'd0);
        send_beat(sat_pkg::ACT_LOOKUP, '0, 6'd5);
        send_beat(sat_pkg::ACT_LOOKUP, '0, 6'd6);
        send_beat(sat_pkg::ACT_LOOKUP, '0, 6'd63);
        send_beat(sat_pkg::ACT_REMOVE, '0, 6'd5);
        send_beat(sat_pkg::ACT_REMOVE, '0, 6'd63);
        send_beat(sat_pkg::ACT_REMOVE, '0, 6'd1);
        idle_cycles(3);
        send_beat(sat_pkg::ACT_LOOKUP, '0, 6'd1);
        send_beat(sat_pkg::ACT_INSERT, 32'h8000_0000, 6'd0);
        send_beat(sat_pkg::ACT_INSERT, 32'h7FFF_FFFF, 6'd0);
        send_beat(sat_pkg::ACT_REMOVE, '0, 6'd0);
        send_beat(sat_pkg::ACT_LOOKUP, '0, 6'd0);
        send_beat(sat_pkg::ACT_LOOKUP, '0, 6'd4);
        wait_drained();

        // random: start with a fill-heavy stretch so the table reaches full
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        mix        = MIX_FILL;
        epoch_left = 150;
        while (sent < RANDOM_BEATS)
        begin
            if (!hold_done && sent >= 300)
            begin
                // back-to-back beats against a stalled receiver
                hold_done = 1'b1;
                long_hold_wanted = 1'b1;
                burst_len = 50;
                gap = 0;
            end
            else if (!drain_done && sent >= 650)
            begin
                drain_done = 1'b1;
                wait_drained();
                burst_len = $urandom_range(1, 12);
                gap = 0;
            end
            else
            begin
                burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            repeat (burst_len)
            begin
                if (epoch_left == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       mix = MIX_FILL;
                        1:       mix = MIX_DRAIN;
                        default: mix = MIX_EVEN;
                    endcase
                    epoch_left = $urandom_range(40, 140);
                end
                epoch_left--;
                random_beat(mix);
                if (req_ch.action != ACT_UNUSED)
                    sent++;
            end
            if (gap != 0)
                idle_cycles(gap);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d result beats: %0d dropped inserts on a full table,",
                 checked, full_seen);
        $display("%0d out-of-range indexes, peak fill %0d of %0d slots.",
                 range_seen, peak_fill, sat_pkg::CAPACITY);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sat_pkg.sv
rtl/core/sat_req_if.sv
rtl/core/sat_rsp_if.sv
rtl/core/sat_cell.sv
rtl/core/sorted_array_table.sv
verif/sorted_array_table_checker.sv
verif/sorted_array_table_tb.sv
